FILE: rtl/crg_pkg.sv
// Shared definitions for the camera ray generator.
// Holds the configuration register indexes; no dependencies.
package crg_pkg;

	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_VIEWPORT_CENTRE = 3'd0,
		CFG_U_PIXEL_STEP    = 3'd1,
		CFG_V_PIXEL_STEP    = 3'd2,
		CFG_CAMERA_POSITION = 3'd3,
		CFG_SCREEN_WIDTH    = 3'd4,
		CFG_SCREEN_HEIGHT   = 3'd5
	} cfg_idx_t;

endpackage

FILE: rtl/crg_div_lane.sv
// Pipelined restoring divider for one direction component: one quotient bit a stage.
// Computes round(mag * 2^FB / len) for mag <= len; standalone, no package use.
module crg_div_lane #(
	parameter int VB = 20,
	parameter int FB = 16,
	parameter int RB = 21
) (
	input  logic          clk,
	input  logic          en,
	input  logic [VB-1:0] mag,
	input  logic [RB-1:0] len,
	output logic [FB:0]   quo
);
	localparam int QB = FB + 1;
	localparam int NB = VB + FB + 1;

	logic [NB-1:0] num;
	logic [RB-1:0] rem_s [QB];
	logic [QB-1:0] quo_s [QB];
	logic [QB-1:0] low_s [QB];
	logic [RB-1:0] len_s [QB];

	// Adding half the divisor makes the truncating quotient round to nearest.
	assign num = NB'({mag, {FB{1'b0}}}) + NB'(len >> 1);

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [RB-1:0] r_in;
		logic [QB-1:0] q_in;
		logic [QB-1:0] lo_in;
		logic [RB-1:0] l_in;
		logic [RB:0]   rs;

		if (j == 0) begin : g_first
			// The upper part of the numerator is already below the divisor.
			assign r_in  = RB'(num[NB-1:QB]);
			assign q_in  = '0;
			assign lo_in = num[QB-1:0];
			assign l_in  = len;
		end else begin : g_next
			assign r_in  = rem_s[j-1];
			assign q_in  = quo_s[j-1];
			assign lo_in = low_s[j-1];
			assign l_in  = len_s[j-1];
		end

		assign rs = {r_in, lo_in[QB-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (rs >= {1'b0, l_in}) begin
					rem_s[j] <= RB'(rs - {1'b0, l_in});
					quo_s[j] <= {q_in[QB-2:0], 1'b1};
				end else begin
					rem_s[j] <= rs[RB-1:0];
					quo_s[j] <= {q_in[QB-2:0], 1'b0};
				end
				low_s[j] <= {lo_in[QB-2:0], 1'b0};
				len_s[j] <= l_in;
			end
		end
	end

	assign quo = quo_s[QB-1];

endmodule

FILE: rtl/camera_ray_generator.sv
// Camera ray generator top level: origin arithmetic, square-root pipeline, dividers, output word.
// Depends on crg_pkg and crg_div_lane.
//
// Usage: each word on the s_ channel is one pixel (pixel_x, pixel_y). For each
// one the m_ channel carries one word with the saturated ray origin on the image
// plane and the unit direction from the camera position through it.
// Configuration must be written through cfg_we / cfg_index / cfg_data only while
// the block is idle; the block itself does not enforce this. It takes effect at
// once and is not read back. Throughput is one word per clock while the receiver
// keeps m_tready high. The pipeline is six stages of origin arithmetic, then the
// square root, which resolves one root bit a stage over FRAC_BITS+5 stages, then
// the three dividers, one quotient bit a stage over FRAC_BITS+1 stages, and the
// output register.
// The whole pipeline advances together; when the receiver holds m_tready low with
// a word pending, every stage holds and s_tready drops, so nothing is lost.
// Reset empties the pipeline, zeroes the vectors, and sets the screen to 640x480.
module camera_ray_generator #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [crg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [3*(FRAC_BITS+4)-1:0]          cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pixel_x, pixel_y, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
	output logic [((6*FRAC_BITS+18+7)/8)*8-1:0] m_tdata
);
	import crg_pkg::*;

	localparam int VB    = FRAC_BITS + 4;
	localparam int DB    = FRAC_BITS + 2;
	localparam int SZB   = COORD_BITS + 1;
	localparam int OXB   = COORD_BITS + 3;
	localparam int PB    = VB + OXB;
	localparam int AB    = PB + 3;
	localparam int RB    = VB + 1;
	localparam int SB    = 2 * RB;
	localparam int RW    = RB + 2;
	localparam int QB    = FRAC_BITS + 1;
	localparam int NST   = 6 + RB + QB;
	localparam int OUT_W = ((6*FRAC_BITS+18+7)/8)*8;

	logic [3*VB-1:0] vc_q, us_q, vs_q, cp_q;
	logic [SZB-1:0]  sw_q, sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
			us_q <= '0;
			vs_q <= '0;
			cp_q <= '0;
			sw_q <= SZB'(640);
			sh_q <= SZB'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VIEWPORT_CENTRE: vc_q <= cfg_data;
				CFG_U_PIXEL_STEP:    us_q <= cfg_data;
				CFG_V_PIXEL_STEP:    vs_q <= cfg_data;
				CFG_CAMERA_POSITION: cp_q <= cfg_data;
				CFG_SCREEN_WIDTH:    sw_q <= cfg_data[SZB-1:0];
				CFG_SCREEN_HEIGHT:   sh_q <= cfg_data[SZB-1:0];
				default: ;
			endcase
		end
	end

	logic             en;
	logic [NST-1:0]   vld_s;
	logic             out_vld_q;
	logic [OUT_W-1:0] out_data_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[NST-2:0], s_tvalid};
			out_vld_q <= vld_s[NST-1];
		end
	end

	// Stage 1: doubled pixel offsets from the screen centre.
	logic signed [OXB-1:0] ox2_s1, oy2_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ox2_s1 <= $signed({2'b00, s_tdata[COORD_BITS-1:0], 1'b0}) - $signed({2'b00, sw_q});
			oy2_s1 <= $signed({2'b00, s_tdata[2*COORD_BITS-1:COORD_BITS], 1'b0})
				- $signed({2'b00, sh_q});
		end
	end

	// Stage 2: step products. Stage 3: sum, halve rounding up, saturate.
	logic signed [PB-1:0] pu_s2 [3];
	logic signed [PB-1:0] pv_s2 [3];
	logic [3*VB-1:0]      org_s3;
	logic [3*VB-1:0]      org_c3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pu_s2[i] <= PB'($signed(us_q[i*VB +: VB])) * PB'(ox2_s1);
				pv_s2[i] <= PB'($signed(vs_q[i*VB +: VB])) * PB'(oy2_s1);
			end
		end
	end

	always_comb begin
		logic signed [AB-1:0] acc;
		logic signed [AB-1:0] half;
		for (int i = 0; i < 3; i++) begin
			acc  = AB'($signed({vc_q[i*VB +: VB], 1'b0})) + AB'(pu_s2[i]) + AB'(pv_s2[i])
				+ AB'(1);
			half = acc >>> 1;
			if (half > AB'($signed({1'b0, {(VB-1){1'b1}}})))
				org_c3[i*VB +: VB] = {1'b0, {(VB-1){1'b1}}};
			else if (half < AB'($signed({1'b1, {(VB-1){1'b0}}})))
				org_c3[i*VB +: VB] = {1'b1, {(VB-1){1'b0}}};
			else
				org_c3[i*VB +: VB] = half[VB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) org_s3 <= org_c3;
	end

	// Stage 4: offset from the camera. Stage 5: squares. Stage 6: sum of squares.
	logic [3*VB-1:0] org_s4, org_s5, org_s6;
	logic [3*VB-1:0] mag_s4, mag_s5, mag_s6;
	logic [2:0]      neg_s4, neg_s5, neg_s6;
	logic [2*VB-1:0] sq_s5 [3];
	logic [SB-1:0]   sum_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [VB:0] d;
				d = $signed({org_s3[i*VB+VB-1], org_s3[i*VB +: VB]})
					- $signed({cp_q[i*VB+VB-1], cp_q[i*VB +: VB]});
				neg_s4[i]          <= d[VB];
				mag_s4[i*VB +: VB] <= d[VB] ? VB'(-d) : d[VB-1:0];
			end
			org_s4 <= org_s3;
			for (int i = 0; i < 3; i++)
				sq_s5[i] <= (2*VB)'(mag_s4[i*VB +: VB]) * (2*VB)'(mag_s4[i*VB +: VB]);
			org_s5 <= org_s4;
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			sum_s6 <= SB'(sq_s5[0]) + SB'(sq_s5[1]) + SB'(sq_s5[2]);
			org_s6 <= org_s5;
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
		end
	end

	// Square root: stage 7+k settles root bit k from the top, two radicand bits each.
	logic [RW-1:0]   rem_sr  [RB];
	logic [RB-1:0]   root_sr [RB];
	logic [SB-1:0]   rad_sr  [RB];
	logic [3*VB-1:0] org_sr  [RB];
	logic [3*VB-1:0] mag_sr  [RB];
	logic [2:0]      neg_sr  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		logic [RW-1:0]   r_in, rs, tr;
		logic [RB-1:0]   q_in;
		logic [SB-1:0]   s_in;
		logic [3*VB-1:0] org_in, mag_in;
		logic [2:0]      neg_in;

		if (k == 0) begin : g_first
			assign r_in   = '0;
			assign q_in   = '0;
			assign s_in   = sum_s6;
			assign org_in = org_s6;
			assign mag_in = mag_s6;
			assign neg_in = neg_s6;
		end else begin : g_next
			assign r_in   = rem_sr[k-1];
			assign q_in   = root_sr[k-1];
			assign s_in   = rad_sr[k-1];
			assign org_in = org_sr[k-1];
			assign mag_in = mag_sr[k-1];
			assign neg_in = neg_sr[k-1];
		end

		assign rs = {r_in[RW-3:0], s_in[SB-1 -: 2]};
		assign tr = {q_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (rs >= tr) begin
					rem_sr[k]  <= rs - tr;
					root_sr[k] <= {q_in[RB-2:0], 1'b1};
				end else begin
					rem_sr[k]  <= rs;
					root_sr[k] <= {q_in[RB-2:0], 1'b0};
				end
				rad_sr[k] <= {s_in[SB-3:0], 2'b00};
				org_sr[k] <= org_in;
				mag_sr[k] <= mag_in;
				neg_sr[k] <= neg_in;
			end
		end
	end

	// Division: three lanes, with sign, origin and zero-length flag alongside.
	logic [QB-1:0]   quo [3];
	logic [3*VB-1:0] org_sd  [QB];
	logic [2:0]      neg_sd  [QB];
	logic            zero_sd [QB];

	for (genvar i = 0; i < 3; i++) begin : g_div
		crg_div_lane #(
			.VB(VB),
			.FB(FRAC_BITS),
			.RB(RB)
		) u_div (
			.clk(clk),
			.en (en),
			.mag(mag_sr[RB-1][i*VB +: VB]),
			.len(root_sr[RB-1]),
			.quo(quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			org_sd[0]  <= org_sr[RB-1];
			neg_sd[0]  <= neg_sr[RB-1];
			zero_sd[0] <= (root_sr[RB-1] == '0);
			for (int j = 1; j < QB; j++) begin
				org_sd[j]  <= org_sd[j-1];
				neg_sd[j]  <= neg_sd[j-1];
				zero_sd[j] <= zero_sd[j-1];
			end
		end
	end

	// Output word: the quotient never exceeds one, so the signed form needs no clamp.
	logic [OUT_W-1:0] out_c;
	always_comb begin
		logic [DB-1:0] dv;
		out_c          = '0;
		out_c[3*VB-1:0] = org_sd[QB-1];
		for (int i = 0; i < 3; i++) begin
			if (zero_sd[QB-1])
				dv = '0;
			else if (neg_sd[QB-1][i])
				dv = DB'(-{1'b0, quo[i]});
			else
				dv = {1'b0, quo[i]};
			out_c[3*VB + i*DB +: DB] = dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_data_q <= out_c;
	end

	// A word leaving the last stage must land in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s[NST-1]) |=> m_tvalid)
		else $error("pipeline word dropped at the output register");

	// A stalled pipeline keeps its valid pattern.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved during a stall");

	// A finished square root leaves a remainder of at most twice the root.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[6+RB-1] |-> (rem_sr[RB-1] <= {1'b0, root_sr[RB-1], 1'b0}))
		else $error("square root remainder out of range");

endmodule

FILE: sim/testbench.sv
// Testbench for camera_ray_generator: reset-default, directed, random and back-pressure tests.
// Depends on crg_pkg and the RTL; predicts every ray word in SystemVerilog.
`timescale 1ns / 1ps

module testbench;
	import crg_pkg::*;

	localparam int VB = 20;
	localparam int DB = 18;
	localparam int LATENCY = 45;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [59:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [23:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;

	camera_ray_generator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Shadow copy of the configuration.
	logic [59:0] centre_q, ustep_q, vstep_q, campos_q;
	logic [12:0] width_q, height_q;

	logic [119:0] ray_queue[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int cycles = 0;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready = 1'b0;
			hold_cycles--;
		end else begin
			m_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic longint comp(logic [59:0] v, int i);
		return longint'($signed(v[VB*i +: VB]));
	endfunction

	function automatic longint clamp(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [119:0] ray_for_pixel(logic [11:0] px, logic [11:0] py);
		longint ox2, oy2, acc, a, len;
		longint org[3];
		longint d[3];
		longint unsigned s, m, q;
		logic [119:0] w;
		ox2 = 2 * longint'(px) - longint'(width_q);
		oy2 = 2 * longint'(py) - longint'(height_q);
		s = 0;
		w = '0;
		for (int i = 0; i < 3; i++) begin
			acc = 2 * comp(centre_q, i) + comp(ustep_q, i) * ox2 + comp(vstep_q, i) * oy2;
			a = acc + 1;
			// Halving rounds toward minus infinity.
			a = (a < 0) ? (a - 1) / 2 : a / 2;
			org[i] = clamp(a, VB);
			d[i] = org[i] - comp(campos_q, i);
			m = (d[i] < 0) ? -d[i] : d[i];
			s += m * m;
		end
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			longint dv;
			dv = 0;
			if (len != 0) begin
				m = (d[i] < 0) ? -d[i] : d[i];
				q = ((m << 16) + (len >> 1)) / len;
				dv = clamp((d[i] < 0) ? -longint'(q) : longint'(q), DB);
			end
			w[VB*i +: VB] = org[i][VB-1:0];
			w[3*VB + DB*i +: DB] = dv[DB-1:0];
		end
		return w;
	endfunction

	task automatic report(string what, logic [119:0] got, logic [119:0] exp);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, exp);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			logic [119:0] exp;
			if (ray_queue.size() == 0) begin
				report("unexpected word", m_tdata, '0);
			end else begin
				exp = ray_queue.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (m_tdata[VB*i +: VB] !== exp[VB*i +: VB])
						report($sformatf("origin[%0d]", i), m_tdata, exp);
					if (m_tdata[3*VB + DB*i +: DB] !== exp[3*VB + DB*i +: DB])
						report($sformatf("dir[%0d]", i), m_tdata, exp);
				end
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [59:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		case (idx)
			CFG_VIEWPORT_CENTRE: centre_q = value;
			CFG_U_PIXEL_STEP:    ustep_q = value;
			CFG_V_PIXEL_STEP:    vstep_q = value;
			CFG_CAMERA_POSITION: campos_q = value;
			CFG_SCREEN_WIDTH:    width_q = value[12:0];
			CFG_SCREEN_HEIGHT:   height_q = value[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_pixel(logic [11:0] px, logic [11:0] py);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {py, px};
		do @(posedge clk); while (!s_tready);
		ray_queue = {ray_queue, ray_for_pixel(px, py)};
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (ray_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [59:0] rand_vec();
		return 60'({$urandom, $urandom});
	endfunction

	// Vector with small components, so rays stay mostly inside the Q3.16 range.
	function automatic logic [59:0] small_vec(int bits);
		logic [59:0] v;
		for (int i = 0; i < 3; i++)
			v[VB*i +: VB] = 20'($signed(longint'($urandom_range((1 << bits) - 1))
				- (longint'(1) << (bits - 1))));
		return v;
	endfunction

	task automatic randomize_config();
		write_reg(CFG_VIEWPORT_CENTRE, ($urandom_range(3) == 0) ? rand_vec() : small_vec(19));
		write_reg(CFG_U_PIXEL_STEP, ($urandom_range(7) == 0) ? rand_vec() : small_vec(8));
		write_reg(CFG_V_PIXEL_STEP, ($urandom_range(7) == 0) ? rand_vec() : small_vec(8));
		write_reg(CFG_CAMERA_POSITION, ($urandom_range(3) == 0) ? rand_vec() : small_vec(19));
		write_reg(CFG_SCREEN_WIDTH, 60'($urandom_range(4096, 1)));
		write_reg(CFG_SCREEN_HEIGHT, 60'($urandom_range(4096, 1)));
	endtask

	// All vectors are zero after reset, so every direction is the zero-length case.
	task automatic test_reset_defaults();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd320, 12'd240);
		send_pixel(12'hfff, 12'hfff);
		drain();
	endtask

	task automatic test_directed();
		write_reg(CFG_VIEWPORT_CENTRE, {20'h10000, 20'h7ffff, 20'h80000});
		write_reg(CFG_U_PIXEL_STEP, {20'h00000, 20'h00001, 20'h00100});
		write_reg(CFG_V_PIXEL_STEP, {20'hfff00, 20'h00000, 20'hfffff});
		write_reg(CFG_CAMERA_POSITION, {20'h00000, 20'h00000, 20'h00000});
		write_reg(CFG_SCREEN_WIDTH, 60'd4096);
		write_reg(CFG_SCREEN_HEIGHT, 60'd1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hfff, 12'd0);
		send_pixel(12'd0, 12'hfff);
		send_pixel(12'hfff, 12'hfff);
		send_pixel(12'd2048, 12'd0);
		drain();
		// Odd width and a new camera position.
		write_reg(CFG_SCREEN_WIDTH, 60'd1);
		write_reg(CFG_SCREEN_HEIGHT, 60'd4096);
		write_reg(CFG_CAMERA_POSITION, {20'h10000, 20'h7ffff, 20'h7ff80});
		send_pixel(12'd0, 12'd2048);
		send_pixel(12'd1, 12'd2048);
		send_pixel(12'hfff, 12'd4095);
		drain();
		// Huge steps drive the origin into saturation on both sides.
		write_reg(CFG_U_PIXEL_STEP, {20'h7ffff, 20'h80000, 20'h7ffff});
		write_reg(CFG_V_PIXEL_STEP, {20'h80000, 20'h7ffff, 20'h80000});
		write_reg(CFG_CAMERA_POSITION, 60'hfff_ffff_ffff_ffff);
		write_reg(CFG_SCREEN_WIDTH, 60'd333);
		write_reg(CFG_SCREEN_HEIGHT, 60'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hfff, 12'hfff);
		send_pixel(12'h555, 12'haaa);
		send_pixel(12'haaa, 12'h555);
		drain();
	endtask

	task automatic test_random();
		int idles[4] = '{0, 49, 0, 13};
		int stalls[4] = '{0, 0, 49, 13};
		for (int p = 0; p < 4; p++) begin
			for (int c = 0; c < 3; c++) begin
				randomize_config();
				idle_pct = idles[p];
				stall_pct = stalls[p];
				for (int n = 0; n < 55; n++) begin
					if ($urandom_range(3) == 0)
						send_pixel(12'($urandom), 12'($urandom));
					else
						send_pixel(12'($urandom_range(width_q)), 12'($urandom_range(height_q)));
				end
				drain();
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	// The receiver holds off long enough that the pipeline fills and input stalls.
	task automatic test_backpressure();
		randomize_config();
		@(negedge clk);
		hold_cycles = 300;
		for (int n = 0; n < 80; n++)
			send_pixel(12'($urandom), 12'($urandom));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		centre_q = '0;
		ustep_q = '0;
		vstep_q = '0;
		campos_q = '0;
		width_q = 13'd640;
		height_q = 13'd480;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_directed();
		test_random();
		test_backpressure();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
